// ----- hw/rtl/tsae_pkg.sv -----
// tsae_pkg: shared types, constants and arithmetic helpers of the track
// speed and acceleration estimator. No dependencies.
package tsae_pkg;

	// field and datapath widths
	localparam int TIME_W    = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int POS_W     = 17;
	localparam int VEL_W     = 24;
	localparam int MAG_W     = 24;
	localparam int MUL_A_W   = 25;
	localparam int MUL_B_W   = 17;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int RAD_W     = 2 * MAG_W;
	localparam int REM_W     = MAG_W + 3;

	// job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// square root: two result bits per cycle
	localparam int ROOT_STEPS = MAG_W / 2;
	localparam int STEP_W     = $clog2(ROOT_STEPS);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_TWO_DT   = 2'd2;

	localparam logic [CFG_W-1:0] INV_TWO_DT_RESET = 16'd640;

	// saturation bounds for velocity and acceleration components
	localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((2 ** (VEL_W - 1)) - 1);
	localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);
	localparam logic signed [PROD_W-1:0] RATE_ROUND = PROD_W'(128);

	typedef struct packed {
		logic [CFG_W-1:0] pitch_length;
		logic [CFG_W-1:0] pitch_width;
		logic [CFG_W-1:0] inv_two_dt;
	} cfg_t;

	// one result to be finished by the back part
	typedef struct packed {
		logic [TIME_W-1:0]       sample_time;
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic                    speed_ok;
		logic signed [VEL_W-1:0] acc_x;
		logic signed [VEL_W-1:0] acc_y;
		logic                    accel_ok;
		logic                    final_res;
	} job_t;

	typedef struct packed {
		logic [TIME_W-1:0] sample_time;
		logic [MAG_W-1:0]  speed;
		logic [MAG_W-1:0]  accel;
		logic              speed_ok;
		logic              accel_ok;
		logic [MAG_W-1:0]  peak_speed;
		logic              final_res;
	} result_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [MAG_W-1:0] root;
	} root_t;

	// round to nearest by 1/256 and clamp to signed 24 bits
	function automatic logic signed [VEL_W-1:0] rate_scale(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] r;
		r = (p + RATE_ROUND) >>> 8;
		if (r > SAT_HI) begin
			r = SAT_HI;
		end else if (r < SAT_LO) begin
			r = SAT_LO;
		end
		return r[VEL_W-1:0];
	endfunction

	// magnitude of a signed component
	function automatic logic [MAG_W-1:0] abs_val(input logic signed [VEL_W-1:0] v);
		logic [MAG_W-1:0] u;
		u = v;
		if (v[VEL_W-1]) begin
			u = ~u + MAG_W'(1);
		end
		return u;
	endfunction

	// one restoring digit of an integer square root
	function automatic root_t isqrt_step(input root_t s, input logic [1:0] pair);
		logic [REM_W-1:0] r;
		logic [REM_W-1:0] trial;
		root_t n;
		r = {s.rem[REM_W-3:0], pair};
		trial = {1'b0, s.root, 2'b01};
		if (r >= trial) begin
			n.rem = r - trial;
			n.root = {s.root[MAG_W-2:0], 1'b1};
		end else begin
			n.rem = r;
			n.root = {s.root[MAG_W-2:0], 1'b0};
		end
		return n;
	endfunction

endpackage

// ----- hw/rtl/tsae_front.sv -----
// tsae_front: accepts samples, converts positions to mm, forms velocity and
// acceleration components on one shared multiplier and emits result jobs.
// Depends on tsae_pkg.
module tsae_front #(
	parameter int POSITION_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [tsae_pkg::TIME_W-1:0]  time_stamp,
	input  logic [POSITION_BITS-1:0]     x_norm,
	input  logic [POSITION_BITS-1:0]     y_norm,
	input  logic                         last,
	input  tsae_pkg::cfg_t               cfg,
	output logic                         job_push,
	output tsae_pkg::job_t               job,
	input  logic                         job_full
);
	import tsae_pkg::*;

	localparam logic [POSITION_BITS:0] CENTER = (POSITION_BITS + 1)'(1) << (POSITION_BITS - 1);
	localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(1) << (POSITION_BITS - 1);

	typedef enum logic [3:0] {
		F_IDLE, F_PX, F_PY, F_VX, F_VY, F_AX, F_AY, F_AW, F_E0, F_E1, F_E2
	} fstate_t;

	fstate_t state_q;

	logic [TIME_W-1:0]        t_q;
	logic [POSITION_BITS-1:0] xn_q;
	logic [POSITION_BITS-1:0] yn_q;
	logic                     last_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [POS_W-1:0]  px_q;
	logic signed [POS_W-1:0]  py_q;
	logic signed [VEL_W-1:0]  vx_q;
	logic signed [VEL_W-1:0]  vy_q;
	logic signed [VEL_W-1:0]  ax_q;
	logic signed [VEL_W-1:0]  ay_q;

	logic signed [POS_W-1:0]  pos_x_hist_q [2];
	logic signed [POS_W-1:0]  pos_y_hist_q [2];
	logic signed [VEL_W-1:0]  vel_x_hist_q [2];
	logic signed [VEL_W-1:0]  vel_y_hist_q [2];
	logic [TIME_W-1:0]        time_hist_q  [2];
	logic [1:0]               count_q;
	logic                     vel_pair_ok_q;

	logic ge2;
	logic ge3;
	assign ge2 = count_q[1];
	assign ge3 = &count_q;

	// centered coordinates and differences
	logic [POSITION_BITS:0]  cx;
	logic [POSITION_BITS:0]  cy;
	logic signed [POS_W:0]   dx;
	logic signed [POS_W:0]   dy;
	logic signed [VEL_W:0]   dvx;
	logic signed [VEL_W:0]   dvy;
	assign cx  = {1'b0, xn_q} - CENTER;
	assign cy  = {1'b0, yn_q} - CENTER;
	assign dx  = {px_q[POS_W-1], px_q} - {pos_x_hist_q[1][POS_W-1], pos_x_hist_q[1]};
	assign dy  = {py_q[POS_W-1], py_q} - {pos_y_hist_q[1][POS_W-1], pos_y_hist_q[1]};
	assign dvx = {vx_q[VEL_W-1], vx_q} - {vel_x_hist_q[1][VEL_W-1], vel_x_hist_q[1]};
	assign dvy = {vy_q[VEL_W-1], vy_q} - {vel_y_hist_q[1][VEL_W-1], vel_y_hist_q[1]};

	// shared multiplier operand select
	logic signed [MUL_A_W-1:0] mul_a;
	logic [CFG_W-1:0]          mul_b_u;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_d;

	always_comb begin
		mul_a = '0;
		mul_b_u = '0;
		unique case (state_q)
			F_PX: begin
				mul_a = MUL_A_W'($signed(cx));
				mul_b_u = cfg.pitch_length;
			end
			F_PY: begin
				mul_a = MUL_A_W'($signed(cy));
				mul_b_u = cfg.pitch_width;
			end
			F_VX: begin
				mul_a = MUL_A_W'(dx);
				mul_b_u = cfg.inv_two_dt;
			end
			F_VY: begin
				mul_a = MUL_A_W'(dy);
				mul_b_u = cfg.inv_two_dt;
			end
			F_AX: begin
				mul_a = MUL_A_W'(dvx);
				mul_b_u = cfg.inv_two_dt;
			end
			F_AY: begin
				mul_a = MUL_A_W'(dvy);
				mul_b_u = cfg.inv_two_dt;
			end
			default: begin
				mul_a = '0;
				mul_b_u = '0;
			end
		endcase
	end

	assign mul_b  = $signed({1'b0, mul_b_u});
	assign prod_d = mul_a * mul_b;

	// product to whole millimetres, rounded half up
	logic signed [PROD_W-1:0] pos_full;
	logic signed [POS_W-1:0]  pos_mm;
	assign pos_full = (prod_q + HALF_P) >>> POSITION_BITS;
	assign pos_mm   = pos_full[POS_W-1:0];

	logic signed [VEL_W-1:0] rate_val;
	assign rate_val = rate_scale(prod_q);

	// job select and emit condition
	logic emit_need;
	logic emit_state;
	always_comb begin
		job = '0;
		emit_need = 1'b0;
		emit_state = 1'b0;
		unique case (state_q)
			F_E0: begin
				emit_state = 1'b1;
				emit_need = ge2;
				job.sample_time = time_hist_q[1];
				job.vel_x = vel_x_hist_q[0];
				job.vel_y = vel_y_hist_q[0];
				job.speed_ok = ge3;
				job.acc_x = ax_q;
				job.acc_y = ay_q;
				job.accel_ok = vel_pair_ok_q;
			end
			F_E1: begin
				emit_state = 1'b1;
				emit_need = last_q && (count_q != 2'd0);
				job.sample_time = time_hist_q[0];
				job.vel_x = vx_q;
				job.vel_y = vy_q;
				job.speed_ok = ge2;
			end
			F_E2: begin
				emit_state = 1'b1;
				emit_need = last_q;
				job.sample_time = t_q;
				job.final_res = 1'b1;
			end
			default: begin
				emit_state = 1'b0;
			end
		endcase
	end

	logic emit_go;
	assign emit_go  = emit_state && (!emit_need || !job_full);
	assign job_push = emit_state && emit_need && !job_full;
	assign full     = (state_q != F_IDLE);

	// sequencer and track history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			t_q <= '0;
			xn_q <= '0;
			yn_q <= '0;
			last_q <= 1'b0;
			prod_q <= '0;
			px_q <= '0;
			py_q <= '0;
			vx_q <= '0;
			vy_q <= '0;
			ax_q <= '0;
			ay_q <= '0;
			for (int i = 0; i < 2; i++) begin
				pos_x_hist_q[i] <= '0;
				pos_y_hist_q[i] <= '0;
				vel_x_hist_q[i] <= '0;
				vel_y_hist_q[i] <= '0;
				time_hist_q[i] <= '0;
			end
			count_q <= '0;
			vel_pair_ok_q <= 1'b0;
		end else begin
			prod_q <= prod_d;
			unique case (state_q)
				F_IDLE: begin
					if (push) begin
						t_q <= time_stamp;
						xn_q <= x_norm;
						yn_q <= y_norm;
						last_q <= last;
						state_q <= F_PX;
					end
				end
				F_PX: state_q <= F_PY;
				F_PY: begin
					px_q <= pos_mm;
					state_q <= F_VX;
				end
				F_VX: begin
					py_q <= pos_mm;
					state_q <= F_VY;
				end
				F_VY: begin
					vx_q <= rate_val;
					state_q <= F_AX;
				end
				F_AX: begin
					vy_q <= rate_val;
					state_q <= F_AY;
				end
				F_AY: begin
					ax_q <= rate_val;
					state_q <= F_AW;
				end
				F_AW: begin
					ay_q <= rate_val;
					state_q <= F_E0;
				end
				F_E0: begin
					if (emit_go) begin
						state_q <= F_E1;
					end
				end
				F_E1: begin
					if (emit_go) begin
						state_q <= F_E2;
					end
				end
				F_E2: begin
					if (emit_go) begin
						state_q <= F_IDLE;
						if (last_q) begin
							for (int i = 0; i < 2; i++) begin
								pos_x_hist_q[i] <= '0;
								pos_y_hist_q[i] <= '0;
								vel_x_hist_q[i] <= '0;
								vel_y_hist_q[i] <= '0;
								time_hist_q[i] <= '0;
							end
							count_q <= '0;
							vel_pair_ok_q <= 1'b0;
						end else begin
							if (ge2) begin
								vel_x_hist_q[1] <= vel_x_hist_q[0];
								vel_x_hist_q[0] <= vx_q;
								vel_y_hist_q[1] <= vel_y_hist_q[0];
								vel_y_hist_q[0] <= vy_q;
								vel_pair_ok_q <= ge3;
							end
							pos_x_hist_q[1] <= pos_x_hist_q[0];
							pos_x_hist_q[0] <= px_q;
							pos_y_hist_q[1] <= pos_y_hist_q[0];
							pos_y_hist_q[0] <= py_q;
							time_hist_q[1] <= time_hist_q[0];
							time_hist_q[0] <= t_q;
							if (!ge3) begin
								count_q <= count_q + 2'd1;
							end
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/tsae_queue.sv -----
// tsae_queue: short job queue that decouples the front and back parts.
// Depends on tsae_pkg.
module tsae_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tsae_pkg::job_t wr_job,
	output logic           full,
	input  logic           pop,
	output tsae_pkg::job_t rd_job,
	output logic           empty
);
	import tsae_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign full   = (fill_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty  = (fill_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	logic do_push;
	logic do_pop;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (QPTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - (QPTR_W + 1)'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// ----- hw/rtl/tsae_back.sv -----
// tsae_back: squares, two iterative square roots, peak tracking and the
// result register. Depends on tsae_pkg.
module tsae_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tsae_pkg::job_t    job,
	input  logic              job_empty,
	output logic              job_pop,
	output tsae_pkg::result_t result,
	output logic              empty,
	input  logic              pop
);
	import tsae_pkg::*;

	typedef enum logic [2:0] {B_IDLE, B_SQ, B_SUM, B_ROOT, B_DONE} bstate_t;

	bstate_t state_q;

	logic [TIME_W-1:0] time_q;
	logic              sok_q;
	logic              aok_q;
	logic              fin_q;
	logic [MAG_W-1:0]  abs_vx_q;
	logic [MAG_W-1:0]  abs_vy_q;
	logic [MAG_W-1:0]  abs_ax_q;
	logic [MAG_W-1:0]  abs_ay_q;
	logic [RAD_W-1:0]  sq_vx_q;
	logic [RAD_W-1:0]  sq_vy_q;
	logic [RAD_W-1:0]  sq_ax_q;
	logic [RAD_W-1:0]  sq_ay_q;
	logic [RAD_W-1:0]  rad_s_q;
	logic [RAD_W-1:0]  rad_a_q;
	root_t             root_s_q;
	root_t             root_a_q;
	logic [STEP_W-1:0] step_q;
	logic [MAG_W-1:0]  peak_q;
	logic              out_valid_q;
	result_t           out_q;

	assign job_pop = (state_q == B_IDLE) && !job_empty;
	assign empty   = !out_valid_q;
	assign result  = out_q;

	// two digits per cycle for both roots
	root_t root_s_mid;
	root_t root_a_mid;
	root_t root_s_nxt;
	root_t root_a_nxt;
	assign root_s_mid = isqrt_step(root_s_q, rad_s_q[RAD_W-1 -: 2]);
	assign root_s_nxt = isqrt_step(root_s_mid, rad_s_q[RAD_W-3 -: 2]);
	assign root_a_mid = isqrt_step(root_a_q, rad_a_q[RAD_W-1 -: 2]);
	assign root_a_nxt = isqrt_step(root_a_mid, rad_a_q[RAD_W-3 -: 2]);

	// finished result and updated peak
	logic [MAG_W-1:0] spd;
	logic [MAG_W-1:0] acc;
	logic [MAG_W-1:0] peak_new;
	logic             out_free;
	logic             out_load;
	assign spd      = sok_q ? root_s_q.root : '0;
	assign acc      = aok_q ? root_a_q.root : '0;
	assign peak_new = (sok_q && (spd > peak_q)) ? spd : peak_q;
	assign out_free = !out_valid_q || pop;
	assign out_load = (state_q == B_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			time_q <= '0;
			sok_q <= 1'b0;
			aok_q <= 1'b0;
			fin_q <= 1'b0;
			abs_vx_q <= '0;
			abs_vy_q <= '0;
			abs_ax_q <= '0;
			abs_ay_q <= '0;
			sq_vx_q <= '0;
			sq_vy_q <= '0;
			sq_ax_q <= '0;
			sq_ay_q <= '0;
			rad_s_q <= '0;
			rad_a_q <= '0;
			root_s_q <= '0;
			root_a_q <= '0;
			step_q <= '0;
			peak_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			// result register handshake
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!job_empty) begin
						time_q <= job.sample_time;
						sok_q <= job.speed_ok;
						aok_q <= job.accel_ok;
						fin_q <= job.final_res;
						abs_vx_q <= abs_val(job.vel_x);
						abs_vy_q <= abs_val(job.vel_y);
						abs_ax_q <= abs_val(job.acc_x);
						abs_ay_q <= abs_val(job.acc_y);
						state_q <= B_SQ;
					end
				end
				B_SQ: begin
					sq_vx_q <= abs_vx_q * abs_vx_q;
					sq_vy_q <= abs_vy_q * abs_vy_q;
					sq_ax_q <= abs_ax_q * abs_ax_q;
					sq_ay_q <= abs_ay_q * abs_ay_q;
					state_q <= B_SUM;
				end
				B_SUM: begin
					rad_s_q <= sq_vx_q + sq_vy_q;
					rad_a_q <= sq_ax_q + sq_ay_q;
					root_s_q <= '0;
					root_a_q <= '0;
					step_q <= '0;
					state_q <= B_ROOT;
				end
				B_ROOT: begin
					root_s_q <= root_s_nxt;
					root_a_q <= root_a_nxt;
					rad_s_q <= rad_s_q << 4;
					rad_a_q <= rad_a_q << 4;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (out_free) begin
						out_q.sample_time <= time_q;
						out_q.speed <= spd;
						out_q.accel <= acc;
						out_q.speed_ok <= sok_q;
						out_q.accel_ok <= aok_q;
						out_q.peak_speed <= peak_new;
						out_q.final_res <= fin_q;
						peak_q <= fin_q ? '0 : peak_new;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/track_speed_accel_estimator_core.sv -----
// Track speed and acceleration estimator. Samples go in through a queue-style
// port (push/full) and results come out the same way (empty/pop). The result
// of a sample appears once the sample two later is taken; a sample marked last
// flushes the pending results, so a sample yields zero to three results, and
// final_res marks the last result of the track. The front part takes a sample
// in its idle state, forms six products through its single shared multiplier
// in states F_PX to F_AW and passes three emit slots, which wait while the job
// queue is full; it takes no new sample until its last emit slot is done. The
// back part squares and sums the components, then runs two square-root units
// that produce two bits per cycle, and waits for a free result register.
// Configuration writes apply from the next sample and should be made while
// the block is idle.
// Depends on tsae_pkg, tsae_front, tsae_queue and tsae_back.
module track_speed_accel_estimator_core #(
	parameter int POSITION_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [tsae_pkg::TIME_W-1:0]    time_stamp,
	input  logic [POSITION_BITS-1:0]       x_norm,
	input  logic [POSITION_BITS-1:0]       y_norm,
	input  logic                           last,
	output logic                           empty,
	input  logic                           pop,
	output logic [tsae_pkg::TIME_W-1:0]    sample_time,
	output logic [tsae_pkg::MAG_W-1:0]     speed,
	output logic [tsae_pkg::MAG_W-1:0]     accel,
	output logic                           speed_ok,
	output logic                           accel_ok,
	output logic [tsae_pkg::MAG_W-1:0]     peak_speed,
	output logic                           final_res,
	input  logic                           cfg_wr_en,
	input  logic [tsae_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsae_pkg::CFG_W-1:0]     cfg_data
);
	import tsae_pkg::*;

	cfg_t    cfg_q;
	job_t    fr_job;
	job_t    q_job;
	logic    fr_push;
	logic    q_full;
	logic    q_empty;
	logic    q_pop;
	result_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pitch_length <= '0;
			cfg_q.pitch_width <= '0;
			cfg_q.inv_two_dt <= INV_TWO_DT_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_PITCH_LENGTH) begin
				cfg_q.pitch_length <= cfg_data;
			end else if (cfg_index == REG_PITCH_WIDTH) begin
				cfg_q.pitch_width <= cfg_data;
			end else if (cfg_index == REG_INV_TWO_DT) begin
				cfg_q.inv_two_dt <= cfg_data;
			end
		end
	end

	// sample intake and job generation
	tsae_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.time_stamp(time_stamp),
		.x_norm    (x_norm),
		.y_norm    (y_norm),
		.last      (last),
		.cfg       (cfg_q),
		.job_push  (fr_push),
		.job       (fr_job),
		.job_full  (q_full)
	);

	// job queue
	tsae_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fr_push),
		.wr_job(fr_job),
		.full  (q_full),
		.pop   (q_pop),
		.rd_job(q_job),
		.empty (q_empty)
	);

	// magnitudes and result register
	tsae_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (q_job),
		.job_empty(q_empty),
		.job_pop  (q_pop),
		.result   (res),
		.empty    (empty),
		.pop      (pop)
	);

	// result ports
	assign sample_time = res.sample_time;
	assign speed       = res.speed;
	assign accel       = res.accel;
	assign speed_ok    = res.speed_ok;
	assign accel_ok    = res.accel_ok;
	assign peak_speed  = res.peak_speed;
	assign final_res   = res.final_res;

endmodule

// ----- tb/tsae_checker.sv -----
`timescale 1ns / 1ps
// tsae_checker: watches the sample, result and register ports of the track
// speed and acceleration estimator, predicts every result and compares them.
// Depends on tsae_pkg.
module tsae_checker #(
	parameter int POSITION_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           full,
	input  logic [tsae_pkg::TIME_W-1:0]    time_stamp,
	input  logic [POSITION_BITS-1:0]       x_norm,
	input  logic [POSITION_BITS-1:0]       y_norm,
	input  logic                           last,
	input  logic                           empty,
	input  logic                           pop,
	input  logic [tsae_pkg::TIME_W-1:0]    sample_time,
	input  logic [tsae_pkg::MAG_W-1:0]     speed,
	input  logic [tsae_pkg::MAG_W-1:0]     accel,
	input  logic                           speed_ok,
	input  logic                           accel_ok,
	input  logic [tsae_pkg::MAG_W-1:0]     peak_speed,
	input  logic                           final_res,
	input  logic                           cfg_wr_en,
	input  logic [tsae_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsae_pkg::CFG_W-1:0]     cfg_data,
	output int                             fail_count,
	output int                             pending,
	output int                             checked
);
	import tsae_pkg::*;

	localparam longint HALF         = longint'(1) << (POSITION_BITS - 1);
	localparam longint COMP_MAX     = (longint'(1) << (VEL_W - 1)) - 1;
	localparam longint COMP_MIN     = -(longint'(1) << (VEL_W - 1));
	localparam int     REPORT_LIMIT = 10;

	// register copies
	logic [CFG_W-1:0] len_mm;
	logic [CFG_W-1:0] wid_mm;
	logic [CFG_W-1:0] inv_rate;

	// track history, index 0 is the newest sample
	longint            pos_x [2];
	longint            pos_y [2];
	longint            vel_x [2];
	longint            vel_y [2];
	logic [TIME_W-1:0] stamp_hist [2];
	int                track_len;
	bit                vel_pair;
	logic [MAG_W-1:0]  peak;

	result_t expected_q [$];
	int      bad_count;
	int      match_count;

	// centered position in whole mm, rounded half up
	function automatic longint scale_mm(input logic [POSITION_BITS-1:0] norm,
			input logic [CFG_W-1:0] pitch);
		longint c;
		c = longint'(norm) - HALF;
		return (c * longint'(pitch) + HALF) >>> POSITION_BITS;
	endfunction

	// difference times 1/(2 dt), rounded and clamped to 24 signed bits
	function automatic longint per_second(input longint diff);
		longint r;
		r = (diff * longint'(inv_rate) + 128) >>> 8;
		if (r > COMP_MAX) begin
			r = COMP_MAX;
		end else if (r < COMP_MIN) begin
			r = COMP_MIN;
		end
		return r;
	endfunction

	// floor of the euclidean length of (a, b)
	function automatic logic [MAG_W-1:0] vec_len(input longint a, input longint b);
		longint unsigned rem;
		longint unsigned root;
		longint unsigned probe;
		rem = a * a + b * b;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > rem) probe >>= 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root[MAG_W-1:0];
	endfunction

	function automatic string show(input result_t r);
		return $sformatf("t=%h spd=%0d acc=%0d sok=%b aok=%b peak=%0d fin=%b",
			r.sample_time, r.speed, r.accel, r.speed_ok, r.accel_ok,
			r.peak_speed, r.final_res);
	endfunction

	task automatic clear_history();
		for (int i = 0; i < 2; i++) begin
			pos_x[i] = 0;
			pos_y[i] = 0;
			vel_x[i] = 0;
			vel_y[i] = 0;
			stamp_hist[i] = '0;
		end
		track_len = 0;
		vel_pair = 1'b0;
		peak = '0;
	endtask

	// queue one expected result, invalid values forced to zero
	task automatic post_result(input logic [TIME_W-1:0] t, input bit sok,
			input logic [MAG_W-1:0] spd, input bit aok,
			input logic [MAG_W-1:0] acc, input bit fin);
		result_t r;
		if (!sok) spd = '0;
		if (!aok) acc = '0;
		if (sok && spd > peak) peak = spd;
		r.sample_time = t;
		r.speed = spd;
		r.accel = acc;
		r.speed_ok = sok;
		r.accel_ok = aok;
		r.peak_speed = peak;
		r.final_res = fin;
		expected_q.insert(expected_q.size(), r);
	endtask

	// results caused by one accepted sample
	task automatic predict_sample(input logic [TIME_W-1:0] t,
			input logic [POSITION_BITS-1:0] xn, input logic [POSITION_BITS-1:0] yn,
			input bit fin);
		longint px;
		longint py;
		longint vx;
		longint vy;
		longint ax;
		longint ay;
		bit two;
		bit three;
		px = scale_mm(xn, len_mm);
		py = scale_mm(yn, wid_mm);
		two = track_len >= 2;
		three = track_len >= 3;
		vx = 0;
		vy = 0;
		// result of the sample before the previous one
		if (two) begin
			vx = per_second(px - pos_x[1]);
			vy = per_second(py - pos_y[1]);
			ax = per_second(vx - vel_x[1]);
			ay = per_second(vy - vel_y[1]);
			post_result(stamp_hist[1], three, vec_len(vel_x[0], vel_y[0]),
				vel_pair, vec_len(ax, ay), 1'b0);
			vel_x[1] = vel_x[0];
			vel_x[0] = vx;
			vel_y[1] = vel_y[0];
			vel_y[0] = vy;
			vel_pair = three;
		end
		// flush at the end of a track
		if (fin) begin
			if (track_len >= 1) begin
				post_result(stamp_hist[0], two, vec_len(vx, vy), 1'b0, '0, 1'b0);
			end
			post_result(t, 1'b0, '0, 1'b0, '0, 1'b1);
			clear_history();
		end else begin
			pos_x[1] = pos_x[0];
			pos_x[0] = px;
			pos_y[1] = pos_y[0];
			pos_y[0] = py;
			stamp_hist[1] = stamp_hist[0];
			stamp_hist[0] = t;
			if (track_len < 3) track_len++;
		end
	endtask

	// compare one result transaction with the oldest expectation
	task automatic compare_result();
		result_t got;
		result_t want;
		bit bad;
		got.sample_time = sample_time;
		got.speed = speed;
		got.accel = accel;
		got.speed_ok = speed_ok;
		got.accel_ok = accel_ok;
		got.peak_speed = peak_speed;
		got.final_res = final_res;
		if (expected_q.size() == 0) begin
			if (bad_count < REPORT_LIMIT) begin
				$display("unexpected result: %s", show(got));
			end
			bad_count++;
		end else begin
			want = expected_q.pop_front();
			bad = (got.sample_time !== want.sample_time) || (got.speed !== want.speed) ||
				(got.accel !== want.accel) || (got.speed_ok !== want.speed_ok) ||
				(got.accel_ok !== want.accel_ok) || (got.peak_speed !== want.peak_speed) ||
				(got.final_res !== want.final_res);
			if (bad) begin
				if (bad_count < REPORT_LIMIT) begin
					$display("mismatch on result %0d", match_count + bad_count);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
				bad_count++;
			end else begin
				match_count++;
			end
		end
	endtask

	// watch register writes, results and samples
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_mm = '0;
			wid_mm = '0;
			inv_rate = INV_TWO_DT_RESET;
			clear_history();
			expected_q.delete();
			bad_count = 0;
			match_count = 0;
			fail_count <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_PITCH_LENGTH: len_mm = cfg_data;
					REG_PITCH_WIDTH:  wid_mm = cfg_data;
					REG_INV_TWO_DT:   inv_rate = cfg_data;
					default: ;
				endcase
			end
			if (pop && !empty) compare_result();
			if (push && !full) predict_sample(time_stamp, x_norm, y_norm, last);
			fail_count <= bad_count;
			pending <= expected_q.size();
			checked <= match_count;
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// testbench: clock, reset and stimulus for track_speed_accel_estimator_core,
// with tsae_checker beside the block for prediction. Depends on tsae_pkg.
module testbench;
	import tsae_pkg::*;

	localparam int POS_BITS        = 16;
	localparam int DRAIN_CYCLES    = 120;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int PHASE_SAMPLES   = 28;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [POS_BITS-1:0] POS_MIN = '0;
	localparam logic [POS_BITS-1:0] POS_MAX = '1;
	localparam logic [POS_BITS-1:0] POS_MID = 16'h8000;
	localparam logic [CFG_W-1:0]    CFG_MAX = '1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [TIME_W-1:0]     time_stamp = '0;
	logic [POS_BITS-1:0]   x_norm = '0;
	logic [POS_BITS-1:0]   y_norm = '0;
	logic                  last = 1'b0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [TIME_W-1:0]     sample_time;
	logic [MAG_W-1:0]      speed;
	logic [MAG_W-1:0]      accel;
	logic                  speed_ok;
	logic                  accel_ok;
	logic [MAG_W-1:0]      peak_speed;
	logic                  final_res;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;

	int chk_fails;
	int chk_pending;
	int chk_results;

	int cycle_count = 0;
	int samples_sent = 0;
	int tracks_sent = 0;
	int settings_used = 1;
	int pop_hold = 0;
	int mode_left = 0;
	bit pop_steady = 1'b0;

	always #6 clk = ~clk;

	track_speed_accel_estimator_core #(
		.POSITION_BITS(POS_BITS)
	) i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.time_stamp(time_stamp), .x_norm(x_norm), .y_norm(y_norm), .last(last),
		.empty(empty), .pop(pop), .sample_time(sample_time), .speed(speed),
		.accel(accel), .speed_ok(speed_ok), .accel_ok(accel_ok),
		.peak_speed(peak_speed), .final_res(final_res), .cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tsae_checker #(
		.POSITION_BITS(POS_BITS)
	) i_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.time_stamp(time_stamp), .x_norm(x_norm), .y_norm(y_norm), .last(last),
		.empty(empty), .pop(pop), .sample_time(sample_time), .speed(speed),
		.accel(accel), .speed_ok(speed_ok), .accel_ok(accel_ok),
		.peak_speed(peak_speed), .final_res(final_res), .cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .fail_count(chk_fails),
		.pending(chk_pending), .checked(chk_results)
	);

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(12, 60);
	endfunction

	// small random move along one axis, clamped to the field
	function automatic logic [POS_BITS-1:0] drift(input logic [POS_BITS-1:0] p);
		int q;
		q = int'(p) + int'($urandom_range(0, 1600)) - 800;
		if (q < 0) q = 0;
		if (q > int'(POS_MAX)) q = int'(POS_MAX);
		return q[POS_BITS-1:0];
	endfunction

	// result side: random stalls with stretches of steady popping
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				pop_steady = ($urandom_range(0, 3) == 0);
				mode_left = $urandom_range(50, 400);
			end else begin
				mode_left--;
			end
			if (pop_hold > 0) begin
				pop <= 1'b0;
				pop_hold--;
			end else begin
				pop <= 1'b1;
				if (!pop_steady && $urandom_range(0, 2) == 0) pop_hold = pick_gap();
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles, %0d results outstanding",
				cycle_count, chk_pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic pause(input int n);
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// one sample transaction, then an optional gap
	task automatic put_sample(input logic [TIME_W-1:0] ts, input logic [POS_BITS-1:0] xv,
			input logic [POS_BITS-1:0] yv, input logic fin, input int gap);
		push <= 1'b1;
		time_stamp <= ts;
		x_norm <= xv;
		y_norm <= yv;
		last <= fin;
		do @(posedge clk); while (full);
		samples_sent++;
		pause(gap);
	endtask

	// hold samples until every result is out and the block has gone quiet
	task automatic settle();
		pause(1);
		while (chk_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// new setting, with a write to the unused index that must change nothing
	task automatic set_config(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] wid,
			input logic [CFG_W-1:0] rate);
		write_reg(REG_SPARE, CFG_W'($urandom));
		write_reg(REG_PITCH_LENGTH, len);
		write_reg(REG_PITCH_WIDTH, wid);
		write_reg(REG_INV_TWO_DT, rate);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// one track of n samples, the last one flagged
	task automatic run_track(input int n, input bit noisy);
		logic [POS_BITS-1:0] xv;
		logic [POS_BITS-1:0] yv;
		logic [TIME_W-1:0] ts;
		bit gapless;
		xv = POS_BITS'($urandom);
		yv = POS_BITS'($urandom);
		ts = $urandom;
		gapless = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n; i++) begin
			put_sample(ts, xv, yv, i == n - 1, gapless ? 0 : pick_gap());
			ts += $urandom_range(1, 400);
			if (noisy) begin
				xv = POS_BITS'($urandom);
				yv = POS_BITS'($urandom);
			end else begin
				xv = drift(xv);
				yv = drift(yv);
			end
		end
		tracks_sent++;
	endtask

	initial begin
		logic [CFG_W-1:0] lens [5];
		logic [CFG_W-1:0] wids [5];
		logic [CFG_W-1:0] rates [5];
		int phase_start;
		int r;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: zero pitch, single-sample track
		put_sample(32'd0, POS_MAX, POS_MIN, 1'b1, 0);
		tracks_sent++;
		settle();

		// extreme setting: two-sample track
		set_config(CFG_MAX, CFG_MAX, CFG_MAX);
		put_sample(32'd1, POS_MIN, POS_MAX, 1'b0, pick_gap());
		put_sample(32'd2, POS_MAX, POS_MIN, 1'b1, pick_gap());
		// three-sample track
		put_sample(32'd10, POS_MIN, POS_MIN, 1'b0, pick_gap());
		put_sample(32'd11, POS_MAX, POS_MAX, 1'b0, pick_gap());
		put_sample(32'd12, POS_MID, POS_MID, 1'b1, pick_gap());
		// full swings across the field saturate velocity and acceleration
		put_sample(32'hFFFF_FFFE, POS_MIN, POS_MAX, 1'b0, pick_gap());
		put_sample(32'hFFFF_FFFF, POS_MAX, POS_MIN, 1'b0, pick_gap());
		put_sample(32'h0000_0000, POS_MIN, POS_MAX, 1'b0, pick_gap());
		put_sample(32'h0000_0001, POS_MAX, POS_MIN, 1'b0, pick_gap());
		put_sample(32'h0000_0002, POS_MIN, POS_MAX, 1'b1, pick_gap());
		// four samples near the center
		put_sample(32'd100, POS_MID, POS_MID, 1'b0, pick_gap());
		put_sample(32'd101, POS_MID + 16'd1, POS_MID - 16'd1, 1'b0, pick_gap());
		put_sample(32'd102, POS_MID - 16'd1, POS_MID + 16'd1, 1'b0, pick_gap());
		put_sample(32'd103, POS_MID, POS_MID, 1'b1, pick_gap());
		tracks_sent += 4;
		run_track(6, 1'b0);

		// random part over several settings, extremes among them
		lens[0] = 16'd52500;         wids[0] = 16'd34000;         rates[0] = INV_TWO_DT_RESET;
		lens[1] = '0;                wids[1] = '0;                rates[1] = '0;
		lens[2] = CFG_W'($urandom);  wids[2] = CFG_W'($urandom);  rates[2] = CFG_W'($urandom);
		lens[3] = CFG_MAX;           wids[3] = 16'd1;             rates[3] = 16'd1;
		lens[4] = CFG_W'($urandom);  wids[4] = CFG_W'($urandom);  rates[4] = 16'd256;
		for (int p = 0; p < 5; p++) begin
			settle();
			set_config(lens[p], wids[p], rates[p]);
			phase_start = samples_sent;
			while (samples_sent - phase_start < PHASE_SAMPLES) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					run_track($urandom_range(3, 12), 1'b0);
				end else if (r < 85) begin
					run_track($urandom_range(1, 8), 1'b1);
				end else begin
					run_track($urandom_range(1, 2), $urandom_range(0, 1) == 1);
				end
				if ($urandom_range(0, 9) == 0) settle();
			end
		end

		settle();
		$display("covered %0d samples in %0d tracks under %0d register settings",
			samples_sent, tracks_sent, settings_used);
		$display("%0d results matched, %0d failures", chk_results, chk_fails);
		if (chk_fails == 0 && chk_pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
